// ===== rtl/core/tuf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tuf_pkg
// Shared types, widths and command codes of the threshold union-find block.
// ----------------------------------------------------------------------------
package tuf_pkg;

    localparam int VERT_IN_W        = 12;
    localparam int VERT_IN_SPAN     = 1 << VERT_IN_W;
    localparam int EDGE_W           = 16;
    localparam int RANK_W           = 4;
    localparam int SIZE_W           = 13;
    localparam int K_W              = 20;
    localparam int THR_W            = K_W + 1;
    localparam int DEF_NUM_VERTICES = 4096;
    localparam logic [K_W-1:0] K_RESET = K_W'(300);

    // divider operand select
    localparam logic DSEL_SU = 1'b0;
    localparam logic DSEL_SV = 1'b1;

    typedef struct packed {
        logic                 action;
        logic [VERT_IN_W-1:0] vertex_a;
        logic [VERT_IN_W-1:0] vertex_b;
        logic [EDGE_W-1:0]    edge_weight;
    } t_in_req;

    typedef struct packed {
        logic [VERT_IN_W-1:0] root;
        logic                 different_sets;
        logic                 merged;
    } t_out_req;

    typedef struct packed {
        logic       clr_wr;
        logic       load;
        logic       wrap_take;
        logic       div_start;
        logic       div_sel;
        logic       find_init;
        logic       sel_b;
        logic       walk_step;
        logic       root_take;
        logic       rd_cur;
        logic       comp_wr;
        logic       eval;
        logic       join_gone_wr;
        logic       join_keep_wr;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic need_wrap;
        logic is_find;
        logic div_done;
        logic walk_is_root;
        logic cur_is_root;
        logic roots_differ;
        logic pass;
        logic out_full;
    } t_dp_sts;

endpackage

// ===== rtl/core/tuf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tuf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tuf_div
    import tuf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [K_W-1:0]    i_dividend,
    input  logic [SIZE_W-1:0] i_divisor,
    output logic              o_done,
    output logic [K_W-1:0]    o_quot
);

    localparam int CNT_W = $clog2(K_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [K_W-1:0]    r_q;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] r_div;
    logic [SIZE_W+1:0] trial;

    assign trial = {1'b0, r_rem, r_q[K_W-1]} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(K_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (!trial[SIZE_W+1]) begin
                r_rem <= trial[SIZE_W-1:0];
                r_q   <= {r_q[K_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[SIZE_W-2:0], r_q[K_W-1]};
                r_q   <= {r_q[K_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/core/tuf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tuf_datapath
// Forest memory, walk registers, threshold compare and result register.
// ----------------------------------------------------------------------------
module tuf_datapath
    import tuf_pkg::*;
#(
    parameter int NUM_VERTICES = DEF_NUM_VERTICES
)(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_dp_cmd        i_cmd,
    output t_dp_sts        o_sts,
    input  t_in_req        i_in,
    input  logic           i_cfg_valid,
    input  logic [K_W-1:0] i_cfg_data,
    output t_out_req       o_out,
    output logic           o_out_valid,
    input  logic           i_out_ready
);

    localparam int VW = (NUM_VERTICES > 2) ? $clog2(NUM_VERTICES) : 1;

    // index wrap by reciprocal: q is exact or one short, one subtract fixes it
    localparam int          WRAP_S = 24;
    localparam logic [23:0] WRAP_M = 24'((1 << WRAP_S) / NUM_VERTICES);
    localparam logic [23:0] WRAP_N = 24'(NUM_VERTICES);

    // forest memory, one row per vertex
    logic [VW-1:0]     mem_parent [NUM_VERTICES];
    logic [RANK_W-1:0] mem_rank   [NUM_VERTICES];
    logic [SIZE_W-1:0] mem_size   [NUM_VERTICES];
    logic [EDGE_W-1:0] mem_edge   [NUM_VERTICES];

    logic [VW-1:0]     r_rd_parent;
    logic [RANK_W-1:0] r_rd_rank;
    logic [SIZE_W-1:0] r_rd_size;
    logic [EDGE_W-1:0] r_rd_edge;

    t_in_req           r_in;
    logic [VW-1:0]     r_va, r_vb, r_walk, r_cur, r_ru, r_rv, r_clr_idx;
    logic [RANK_W-1:0] r_rank_u, r_rank_v;
    logic [SIZE_W-1:0] r_size_u, r_size_v;
    logic [EDGE_W-1:0] r_edge_u, r_edge_v;
    logic [K_W-1:0]    r_qu, r_qv, r_k;
    logic              r_diff, r_pass;
    logic              r_div_sel;
    t_out_req          r_out;
    logic              r_out_valid;

    logic [VERT_IN_W-1:0] r_wq_a, r_wq_b;
    logic [SIZE_W-1:0]    r_wr_a, r_wr_b;
    logic [35:0]          wprod_a, wprod_b;
    logic [23:0]          wqn_a, wqn_b, wdiff_a, wdiff_b;
    logic [SIZE_W-1:0]    wrap_a, wrap_b;

    logic              div_done;
    logic [K_W-1:0]    div_quot;
    logic [SIZE_W-1:0] div_divisor;

    logic              we;
    logic [VW-1:0]     wr_addr, wr_parent, rd_addr, keep, gone;
    logic [RANK_W-1:0] wr_rank, rank_new, gone_rank;
    logic [SIZE_W-1:0] wr_size, gone_size;
    logic [EDGE_W-1:0] wr_edge, gone_edge;
    logic              keep_v;
    logic [THR_W-1:0]  tu, tv;

    // wrap pipeline: product, remainder, correction
    assign wprod_a = 36'(r_in.vertex_a) * 36'(WRAP_M);
    assign wprod_b = 36'(r_in.vertex_b) * 36'(WRAP_M);
    assign wqn_a   = 24'(r_wq_a) * WRAP_N;
    assign wqn_b   = 24'(r_wq_b) * WRAP_N;
    assign wdiff_a = 24'(r_in.vertex_a) - wqn_a;
    assign wdiff_b = 24'(r_in.vertex_b) - wqn_b;
    assign wrap_a  = (r_wr_a >= WRAP_N[SIZE_W-1:0]) ? r_wr_a - WRAP_N[SIZE_W-1:0] : r_wr_a;
    assign wrap_b  = (r_wr_b >= WRAP_N[SIZE_W-1:0]) ? r_wr_b - WRAP_N[SIZE_W-1:0] : r_wr_b;

    always_ff @(posedge i_clk) begin
        r_wq_a <= wprod_a[35:24];
        r_wq_b <= wprod_b[35:24];
        r_wr_a <= wdiff_a[SIZE_W-1:0];
        r_wr_b <= wdiff_b[SIZE_W-1:0];
    end

    // divisor: root size, zero taken as one
    assign div_divisor = (i_cmd.div_sel == DSEL_SU) ?
                         ((r_size_u == '0) ? SIZE_W'(1) : r_size_u) :
                         ((r_size_v == '0) ? SIZE_W'(1) : r_size_v);

    tuf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_k),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // join by rank; ties keep vertex_a's root
    assign keep_v    = r_rank_v > r_rank_u;
    assign keep      = keep_v ? r_rv : r_ru;
    assign gone      = keep_v ? r_ru : r_rv;
    assign gone_rank = keep_v ? r_rank_u : r_rank_v;
    assign gone_size = keep_v ? r_size_u : r_size_v;
    assign gone_edge = keep_v ? r_edge_u : r_edge_v;
    assign rank_new  = keep_v ? r_rank_v :
                       ((r_rank_u == r_rank_v) ? r_rank_u + 1'b1 : r_rank_u);

    assign tu = THR_W'(r_edge_u) + THR_W'(r_qu);
    assign tv = THR_W'(r_edge_v) + THR_W'(r_qv);

    assign rd_addr = i_cmd.rd_cur ? r_cur : r_walk;

    always_comb begin
        we        = 1'b1;
        wr_addr   = r_cur;
        wr_parent = r_walk;
        wr_rank   = r_rd_rank;
        wr_size   = r_rd_size;
        wr_edge   = r_rd_edge;
        if (i_cmd.clr_wr) begin
            wr_addr   = r_clr_idx;
            wr_parent = r_clr_idx;
            wr_rank   = '0;
            wr_size   = SIZE_W'(1);
            wr_edge   = '0;
        end else if (i_cmd.join_gone_wr) begin
            wr_addr   = gone;
            wr_parent = keep;
            wr_rank   = gone_rank;
            wr_size   = gone_size;
            wr_edge   = gone_edge;
        end else if (i_cmd.join_keep_wr) begin
            wr_addr   = keep;
            wr_parent = keep;
            wr_rank   = rank_new;
            wr_size   = r_size_u + r_size_v;
            wr_edge   = r_in.edge_weight;
        end else if (!i_cmd.comp_wr) begin
            we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_parent[wr_addr] <= wr_parent;
            mem_rank[wr_addr]   <= wr_rank;
            mem_size[wr_addr]   <= wr_size;
            mem_edge[wr_addr]   <= wr_edge;
        end
        r_rd_parent <= mem_parent[rd_addr];
        r_rd_rank   <= mem_rank[rd_addr];
        r_rd_size   <= mem_size[rd_addr];
        r_rd_edge   <= mem_edge[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            r_k         <= K_RESET;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cfg_valid) begin
                r_k <= i_cfg_data;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in   <= i_in;
            r_va   <= VW'(i_in.vertex_a);
            r_vb   <= VW'(i_in.vertex_b);
            r_diff <= 1'b0;
            r_pass <= 1'b0;
        end else if (i_cmd.wrap_take) begin
            r_va <= VW'(wrap_a);
            r_vb <= VW'(wrap_b);
        end
        if (i_cmd.div_start) begin
            r_div_sel <= i_cmd.div_sel;
        end
        if (div_done) begin
            if (r_div_sel == DSEL_SU) begin
                r_qu <= div_quot;
            end else begin
                r_qv <= div_quot;
            end
        end
        if (i_cmd.find_init) begin
            r_walk <= i_cmd.sel_b ? r_vb : r_va;
        end else if (i_cmd.walk_step) begin
            r_walk <= r_rd_parent;
        end
        if (i_cmd.root_take) begin
            r_cur <= i_cmd.sel_b ? r_vb : r_va;
            if (i_cmd.sel_b) begin
                r_rv     <= r_walk;
                r_rank_v <= r_rd_rank;
                r_size_v <= r_rd_size;
                r_edge_v <= r_rd_edge;
            end else begin
                r_ru     <= r_walk;
                r_rank_u <= r_rd_rank;
                r_size_u <= r_rd_size;
                r_edge_u <= r_rd_edge;
            end
        end else if (i_cmd.comp_wr) begin
            r_cur <= r_rd_parent;
        end
        if (i_cmd.eval) begin
            r_diff <= 1'b1;
            r_pass <= (THR_W'(r_in.edge_weight) < tu) && (THR_W'(r_in.edge_weight) < tv);
        end
        if (i_cmd.out_load) begin
            r_out.root           <= VERT_IN_W'(r_walk);
            r_out.different_sets <= r_diff;
            r_out.merged         <= r_pass;
        end
    end

    assign o_sts.clr_last     = (r_clr_idx == VW'(NUM_VERTICES - 1));
    assign o_sts.need_wrap    = (NUM_VERTICES < VERT_IN_SPAN);
    assign o_sts.is_find      = r_in.action;
    assign o_sts.div_done     = div_done;
    assign o_sts.walk_is_root = (r_rd_parent == r_walk);
    assign o_sts.cur_is_root  = (r_cur == r_walk);
    assign o_sts.roots_differ = (r_ru != r_rv);
    assign o_sts.pass         = r_pass;
    assign o_sts.out_full     = r_out_valid;

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/tuf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tuf_ctrl
// Sequencer: clearing pass, root walks, compression, thresholds, join.
// ----------------------------------------------------------------------------
module tuf_ctrl
    import tuf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_START  = 5'd2;
    localparam logic [4:0] S_WRAP_A = 5'd3;
    localparam logic [4:0] S_WRAP_B = 5'd4;
    localparam logic [4:0] S_INIT   = 5'd5;
    localparam logic [4:0] S_F_RD   = 5'd6;
    localparam logic [4:0] S_F_CHK  = 5'd7;
    localparam logic [4:0] S_C_RD   = 5'd8;
    localparam logic [4:0] S_C_WR   = 5'd9;
    localparam logic [4:0] S_AFTER  = 5'd10;
    localparam logic [4:0] S_DIV_U  = 5'd11;
    localparam logic [4:0] S_DIV_V  = 5'd12;
    localparam logic [4:0] S_EVAL   = 5'd13;
    localparam logic [4:0] S_JOIN_G = 5'd14;
    localparam logic [4:0] S_JOIN_K = 5'd15;
    localparam logic [4:0] S_OUT    = 5'd16;

    localparam logic [1:0] PH_A     = 2'd0;
    localparam logic [1:0] PH_B     = 2'd1;
    localparam logic [1:0] PH_FINAL = 2'd2;

    logic [4:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_phase <= PH_A;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_cmd.sel_b = (r_phase != PH_A);
        case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                n_phase = i_sts.is_find ? PH_FINAL : PH_A;
                if (i_sts.need_wrap) begin
                    n_state = S_WRAP_A;
                end else begin
                    n_state = S_INIT;
                end
            end
            S_WRAP_A: begin
                n_state = S_WRAP_B;
            end
            S_WRAP_B: begin
                o_cmd.wrap_take = 1'b1;
                n_state         = S_INIT;
            end
            S_INIT: begin
                o_cmd.find_init = 1'b1;
                n_state         = S_F_RD;
            end
            S_F_RD: begin
                n_state = S_F_CHK;
            end
            S_F_CHK: begin
                if (i_sts.walk_is_root) begin
                    o_cmd.root_take = 1'b1;
                    n_state         = S_C_RD;
                end else begin
                    o_cmd.walk_step = 1'b1;
                    n_state         = S_F_RD;
                end
            end
            S_C_RD: begin
                if (i_sts.cur_is_root) begin
                    n_state = S_AFTER;
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    n_state      = S_C_WR;
                end
            end
            S_C_WR: begin
                o_cmd.comp_wr = 1'b1;
                n_state       = S_C_RD;
            end
            S_AFTER: begin
                case (r_phase)
                    PH_A: begin
                        n_phase = PH_B;
                        n_state = S_INIT;
                    end
                    PH_B: begin
                        if (i_sts.roots_differ) begin
                            o_cmd.div_start = 1'b1;
                            o_cmd.div_sel   = DSEL_SU;
                            n_state         = S_DIV_U;
                        end else begin
                            n_phase = PH_FINAL;
                            n_state = S_INIT;
                        end
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_DIV_U: begin
                if (i_sts.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DSEL_SV;
                    n_state         = S_DIV_V;
                end
            end
            S_DIV_V: begin
                if (i_sts.div_done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_JOIN_G;
            end
            S_JOIN_G: begin
                if (i_sts.pass) begin
                    o_cmd.join_gone_wr = 1'b1;
                    n_state            = S_JOIN_K;
                end else begin
                    n_phase = PH_FINAL;
                    n_state = S_INIT;
                end
            end
            S_JOIN_K: begin
                o_cmd.join_keep_wr = 1'b1;
                n_phase            = PH_FINAL;
                n_state            = S_INIT;
            end
            S_OUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/threshold_union_find.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_union_find
// Disjoint-set forest with per-component merge thresholds.
// ----------------------------------------------------------------------------
// Use: requests enter on i_valid/o_ready as t_in_req. A merge request
// (action 0) finds both roots with path compression, tests the edge
// weight against largest_edge + k/size of each root and joins by rank;
// a find request (action 1) only walks and compresses vertex_b's path.
// Every request yields one t_out_req on o_valid/i_ready.
// Configuration: i_cfg_valid writes threshold_k; o_cfg_ready is always
// high. Write only while the block is idle.
// One request at a time, all on the single forest memory. Each walk
// steps up the parent links to the root (read, then check), then
// walks the path again and writes the root as each vertex's parent.
// A find walks vertex_b; a merge walks vertex_a, vertex_b, then
// vertex_b again, and when the roots differ runs two divisions in turn
// in the shared serial divider, then the compare and the join test.
// Index wrapping is added when NUM_VERTICES is below 4096. The next
// request can be taken in the cycle after the result is loaded.
// Reset: a clearing pass writes every vertex as its own root (size 1,
// rank 0, edge 0); o_ready stays low meanwhile.
// Stall: a finished result waits in the output register; the next request
// is already taken and worked on, and waits only at its own result.
// ----------------------------------------------------------------------------
module threshold_union_find
    import tuf_pkg::*;
#(
    parameter int NUM_VERTICES = DEF_NUM_VERTICES
)(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  t_in_req        i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output t_out_req       o_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [K_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // config register always writable
    assign o_cfg_ready = 1'b1;

    tuf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tuf_datapath #(
        .NUM_VERTICES (NUM_VERTICES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out       (o_data),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready)
    );

endmodule
